FILE: rtl/planar_texgen_vertex_stage_unit_defines.svh
// ----------------------------------------------------------------------------
// Planar texgen vertex stage - assertion macros
// Shared concurrent assertion forms; clk and rst are taken from the user scope.
// ----------------------------------------------------------------------------
`ifndef PLANAR_TEXGEN_VERTEX_STAGE_UNIT_DEFINES_SVH
`define PLANAR_TEXGEN_VERTEX_STAGE_UNIT_DEFINES_SVH

// plain property check
`define PTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication check
`define PTG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/ptg_pkg.sv
// ----------------------------------------------------------------------------
// Planar texgen vertex stage - package
// Payload types, register indexes and shared constants.
// ----------------------------------------------------------------------------
package ptg_pkg;

  localparam int NUM_REGS    = 8;
  localparam int CFG_INDEX_W = $clog2(NUM_REGS);
  localparam int CFG_DATA_W  = 64;

  localparam logic [15:0] FOG_SCALE  = 16'd48896;
  localparam logic [7:0]  ALPHA_FULL = 8'd255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TEX_S_XY = 3'd0,
    REG_TEX_S_ZD = 3'd1,
    REG_TEX_T_XY = 3'd2,
    REG_TEX_T_ZD = 3'd3,
    REG_LM_S_XY  = 3'd4,
    REG_LM_S_ZD  = 3'd5,
    REG_LM_T_XY  = 3'd6,
    REG_LM_T_ZD  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        fog_in;
    logic [31:0]        color_in;
    logic [15:0]        index_in;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] tex_s;
    logic signed [31:0] tex_t;
    logic signed [31:0] lightmap_s;
    logic signed [31:0] lightmap_t;
    logic [15:0]        fog_out;
    logic [7:0]         fog_alpha;
    logic [31:0]        color_swapped;
    logic [15:0]        index_out;
    logic               last_out;
  } out_item_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

FILE: rtl/ptg_plane.sv
// ----------------------------------------------------------------------------
// Planar texgen vertex stage - plane evaluator
// Three-stage x*a + y*b + z*c + d: multiply, sum, floor/offset/saturate.
// ----------------------------------------------------------------------------
module ptg_plane (
  input  logic                clk,
  input  ptg_pkg::stage_en_t  en,
  input  logic signed [31:0]  x,
  input  logic signed [31:0]  y,
  input  logic signed [31:0]  z,
  input  logic [63:0]         coef_xy,
  input  logic [63:0]         coef_zd,
  output logic signed [31:0]  result
);

  localparam logic signed [50:0] SAT_HI = 51'sd2147483647;
  localparam logic signed [50:0] SAT_LO = -51'sd2147483648;

  logic signed [63:0] p0;
  logic signed [63:0] p1;
  logic signed [63:0] p2;
  logic signed [65:0] sum;
  logic signed [50:0] fl;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      p0 <= 64'(x) * 64'($signed(coef_xy[63:32]));
      p1 <= 64'(y) * 64'($signed(coef_xy[31:0]));
      p2 <= 64'(z) * 64'($signed(coef_zd[63:32]));
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      sum <= 66'(p0) + 66'(p1) + 66'(p2);
    end
  end

  // floor to Q16.16, then add offset
  assign fl = 51'($signed(sum[65:16])) + 51'($signed(coef_zd[31:0]));

  always_ff @(posedge clk) begin
    if (en.s3) begin
      if (fl > SAT_HI) begin
        result <= 32'sh7FFFFFFF;
      end else if (fl < SAT_LO) begin
        result <= 32'sh80000000;
      end else begin
        result <= fl[31:0];
      end
    end
  end

endmodule

FILE: rtl/planar_texgen_vertex_stage_unit.sv
// ----------------------------------------------------------------------------
// Planar texgen vertex stage - top level
// Generates texture and lightmap coordinates from four planes per vertex.
// ----------------------------------------------------------------------------
// Takes one vertex item per clock while in_stall is low and returns one
// result item per accepted item, in order. The three stages are the 32x32
// coefficient multiplies, the three-product sum, and the floor, offset add
// and saturation; each stage holds its own valid bit, so bubbles close up
// under stall and the input stalls only when all three stages hold items
// and the output is stalled. Coefficient registers reset to zero; the user
// must write them only while no item is in flight; the block does not check.
`include "planar_texgen_vertex_stage_unit_defines.svh"

module planar_texgen_vertex_stage_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  ptg_pkg::in_item_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output ptg_pkg::out_item_t                    out_data,
  input  logic                                  cfg_we,
  input  logic [ptg_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [ptg_pkg::CFG_DATA_W-1:0]        cfg_data
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [15:0]        fog;
    logic [7:0]         alpha;
    logic [31:0]        color;
    logic [15:0]        index;
    logic               last;
  } side_t;

  logic [ptg_pkg::CFG_DATA_W-1:0] cfg_regs [ptg_pkg::NUM_REGS];

  logic v1, v2, v3;
  logic r1, r2, r3;
  ptg_pkg::stage_en_t en;
  side_t side1, side2, side3;
  side_t side_in;
  logic [31:0] fog_prod;
  logic signed [31:0] tex_s, tex_t, lm_s, lm_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptg_pkg::NUM_REGS; i++) begin
        cfg_regs[i] <= '0;
      end
    end else if (cfg_we) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  assign r3 = !v3 || !out_stall;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_stall = !r1;
  assign en = '{s1: r1, s2: r2, s3: r3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  assign fog_prod = 32'(in_data.fog_in) * 32'(ptg_pkg::FOG_SCALE);

  always_comb begin
    side_in.x     = in_data.pos_x;
    side_in.y     = in_data.pos_y;
    side_in.z     = in_data.pos_z;
    side_in.fog   = in_data.fog_in;
    side_in.alpha = ptg_pkg::ALPHA_FULL - fog_prod[23:16];
    side_in.color = {in_data.color_in[31:24], in_data.color_in[7:0],
                     in_data.color_in[15:8], in_data.color_in[23:16]};
    side_in.index = in_data.index_in;
    side_in.last  = in_data.last_in;
  end

  always_ff @(posedge clk) begin
    if (r1) side1 <= side_in;
    if (r2) side2 <= side1;
    if (r3) side3 <= side2;
  end

  ptg_plane u_tex_s (
    .clk(clk), .en(en), .x(in_data.pos_x), .y(in_data.pos_y), .z(in_data.pos_z),
    .coef_xy(cfg_regs[ptg_pkg::REG_TEX_S_XY]), .coef_zd(cfg_regs[ptg_pkg::REG_TEX_S_ZD]),
    .result(tex_s)
  );

  ptg_plane u_tex_t (
    .clk(clk), .en(en), .x(in_data.pos_x), .y(in_data.pos_y), .z(in_data.pos_z),
    .coef_xy(cfg_regs[ptg_pkg::REG_TEX_T_XY]), .coef_zd(cfg_regs[ptg_pkg::REG_TEX_T_ZD]),
    .result(tex_t)
  );

  ptg_plane u_lm_s (
    .clk(clk), .en(en), .x(in_data.pos_x), .y(in_data.pos_y), .z(in_data.pos_z),
    .coef_xy(cfg_regs[ptg_pkg::REG_LM_S_XY]), .coef_zd(cfg_regs[ptg_pkg::REG_LM_S_ZD]),
    .result(lm_s)
  );

  ptg_plane u_lm_t (
    .clk(clk), .en(en), .x(in_data.pos_x), .y(in_data.pos_y), .z(in_data.pos_z),
    .coef_xy(cfg_regs[ptg_pkg::REG_LM_T_XY]), .coef_zd(cfg_regs[ptg_pkg::REG_LM_T_ZD]),
    .result(lm_t)
  );

  assign out_valid = v3;

  always_comb begin
    out_data.out_x         = side3.x;
    out_data.out_y         = side3.y;
    out_data.out_z         = side3.z;
    out_data.tex_s         = tex_s;
    out_data.tex_t         = tex_t;
    out_data.lightmap_s    = lm_s;
    out_data.lightmap_t    = lm_t;
    out_data.fog_out       = side3.fog;
    out_data.fog_alpha     = side3.alpha;
    out_data.color_swapped = side3.color;
    out_data.index_out     = side3.index;
    out_data.last_out      = side3.last;
  end

  `PTG_ASSERT_IMPL(a_stall_only_full, in_stall, v1 && v2 && v3 && out_stall, "input stalled with room in pipe")
  `PTG_ASSERT_IMPL(a_stage_advance, v2 && r3, ##1 out_valid, "item lost between stage two and output")
  `PTG_ASSERT_IMPL(a_alpha_aligned, out_valid, out_data.fog_alpha == 8'(ptg_pkg::ALPHA_FULL - 8'((32'(out_data.fog_out) * 32'(ptg_pkg::FOG_SCALE)) >> 16)), "fog alpha misaligned with fog")

endmodule
